### rtl/rbc_pkg.sv
// ----------------------------------------------------------------------------
// rbc_pkg
// Shared types, constants and position helpers of the ring buffer with cursor.
// ----------------------------------------------------------------------------
package rbc_pkg;

	localparam int DEPTH   = 16;
	localparam int POS_W   = 4;
	localparam int CNT_W   = POS_W + 1;
	localparam int ENTRY_W = 16;
	localparam int REQ_W   = 4;

	typedef enum logic [REQ_W-1:0] {
		REQ_ADD      = 4'd0,
		REQ_RM_OLD   = 4'd1,
		REQ_RM_AT    = 4'd2,
		REQ_PEEK_CUR = 4'd3,
		REQ_NEXT     = 4'd4,
		REQ_PREV     = 4'd5,
		REQ_PEEK_AT  = 4'd6,
		REQ_SET_AT   = 4'd7,
		REQ_CLEAR    = 4'd8
	} req_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECODE,
		ST_RDATA,
		ST_SHIFT_RD,
		ST_SHIFT_WR,
		ST_WALK,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic latch;
		logic decode;
		logic rd_capture;
		logic shift_rd;
		logic shift_wr;
		logic walk_step;
		logic out_load;
	} ctl_cmd_t;

	typedef struct packed {
		logic [REQ_W-1:0] req;
		logic             ignore;
		logic             shift_last;
		logic             walk_stop;
	} dp_stat_t;

	function automatic logic [CNT_W-1:0] cap_eff(input logic [CNT_W-1:0] cap_reg);
		logic [CNT_W-1:0] r;
		if (cap_reg == '0) begin
			r = CNT_W'(1);
		end else if (cap_reg > CNT_W'(DEPTH)) begin
			r = CNT_W'(DEPTH);
		end else begin
			r = cap_reg;
		end
		return r;
	endfunction

	function automatic logic [POS_W-1:0] pos_fwd(input logic [POS_W-1:0] p,
		input logic [CNT_W-1:0] cap);
		logic [CNT_W-1:0] p1;
		p1 = {1'b0, p} + CNT_W'(1);
		return (p1 >= cap) ? '0 : p1[POS_W-1:0];
	endfunction

	function automatic logic [POS_W-1:0] pos_back(input logic [POS_W-1:0] p,
		input logic [CNT_W-1:0] cap);
		logic [CNT_W-1:0] c1;
		c1 = cap - CNT_W'(1);
		return (p == '0) ? c1[POS_W-1:0] : p - POS_W'(1);
	endfunction

endpackage

### rtl/rbc_if.sv
// ----------------------------------------------------------------------------
// rbc_if
// Valid/ready channels for request words and result words.
// ----------------------------------------------------------------------------
interface rbc_req_if;
	logic                         valid;
	logic                         ready;
	logic [rbc_pkg::REQ_W-1:0]    req_type;
	logic [rbc_pkg::POS_W-1:0]    slot_index;
	logic [rbc_pkg::ENTRY_W-1:0]  entry_data;
	logic                         entry_present;

	modport source (output valid, req_type, slot_index, entry_data, entry_present,
		input ready);
	modport sink (input valid, req_type, slot_index, entry_data, entry_present,
		output ready);
endinterface

interface rbc_rsp_if;
	logic                         valid;
	logic                         ready;
	logic                         status;
	logic                         out_present;
	logic [rbc_pkg::ENTRY_W-1:0]  out_data;
	logic [rbc_pkg::CNT_W-1:0]    count;
	logic                         full_res;
	logic                         empty_res;
	logic [rbc_pkg::POS_W-1:0]    write_index;
	logic [rbc_pkg::POS_W-1:0]    read_index;
	logic [rbc_pkg::POS_W-1:0]    cursor_index;

	modport source (output valid, status, out_present, out_data, count, full_res,
		empty_res, write_index, read_index, cursor_index, input ready);
	modport sink (input valid, status, out_present, out_data, count, full_res,
		empty_res, write_index, read_index, cursor_index, output ready);
endinterface

### rtl/rbc_ctrl.sv
// ----------------------------------------------------------------------------
// rbc_ctrl
// Controller state machine: sequences each request word through the datapath.
// ----------------------------------------------------------------------------
module rbc_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	input  rbc_pkg::dp_stat_t  stat,
	output rbc_pkg::ctl_cmd_t  cmd
);

	rbc_pkg::state_t state_q;
	rbc_pkg::state_t state_d;
	logic            out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= rbc_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			rbc_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.latch = 1'b1;
					state_d   = rbc_pkg::ST_DECODE;
				end
			end
			rbc_pkg::ST_DECODE: begin
				cmd.decode = 1'b1;
				if (stat.ignore) begin
					state_d = rbc_pkg::ST_FIN;
				end else begin
					unique case (stat.req) inside
						rbc_pkg::REQ_RM_OLD, rbc_pkg::REQ_RM_AT,
						rbc_pkg::REQ_PEEK_CUR, rbc_pkg::REQ_PEEK_AT: begin
							state_d = rbc_pkg::ST_RDATA;
						end
						rbc_pkg::REQ_NEXT, rbc_pkg::REQ_PREV: begin
							state_d = rbc_pkg::ST_WALK;
						end
						default: begin
							state_d = rbc_pkg::ST_FIN;
						end
					endcase
				end
			end
			rbc_pkg::ST_RDATA: begin
				cmd.rd_capture = 1'b1;
				state_d = (stat.req == rbc_pkg::REQ_RM_AT) ? rbc_pkg::ST_SHIFT_RD
					: rbc_pkg::ST_FIN;
			end
			rbc_pkg::ST_SHIFT_RD: begin
				cmd.shift_rd = 1'b1;
				state_d = stat.shift_last ? rbc_pkg::ST_FIN : rbc_pkg::ST_SHIFT_WR;
			end
			rbc_pkg::ST_SHIFT_WR: begin
				cmd.shift_wr = 1'b1;
				state_d      = rbc_pkg::ST_SHIFT_RD;
			end
			rbc_pkg::ST_WALK: begin
				cmd.walk_step = 1'b1;
				if (stat.walk_stop) begin
					state_d = rbc_pkg::ST_FIN;
				end
			end
			rbc_pkg::ST_FIN: begin
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_d      = rbc_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = rbc_pkg::ST_IDLE;
			end
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

### rtl/rbc_dp.sv
// ----------------------------------------------------------------------------
// rbc_dp
// Datapath: slot memory, present bits, positions and the result register.
// ----------------------------------------------------------------------------
module rbc_dp (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_wr_en,
	input  logic [rbc_pkg::CNT_W-1:0]    cfg_wr_data,
	input  rbc_pkg::ctl_cmd_t            cmd,
	output rbc_pkg::dp_stat_t            stat,
	input  logic [rbc_pkg::REQ_W-1:0]    req_type,
	input  logic [rbc_pkg::POS_W-1:0]    slot_index,
	input  logic [rbc_pkg::ENTRY_W-1:0]  entry_data,
	input  logic                         entry_present,
	output logic                         status,
	output logic                         out_present,
	output logic [rbc_pkg::ENTRY_W-1:0]  out_data,
	output logic [rbc_pkg::CNT_W-1:0]    count,
	output logic                         full_res,
	output logic                         empty_res,
	output logic [rbc_pkg::POS_W-1:0]    write_index,
	output logic [rbc_pkg::POS_W-1:0]    read_index,
	output logic [rbc_pkg::POS_W-1:0]    cursor_index
);

	logic [rbc_pkg::ENTRY_W-1:0] mem [rbc_pkg::DEPTH];
	logic [rbc_pkg::ENTRY_W-1:0] rdata_q;
	logic [rbc_pkg::DEPTH-1:0]   present_q;
	logic [rbc_pkg::CNT_W-1:0]   cap_q;
	logic [rbc_pkg::POS_W-1:0]   wp_q, rp_q, cur_q, shift_q;
	logic                        full_q;

	logic [rbc_pkg::REQ_W-1:0]   req_q;
	logic [rbc_pkg::POS_W-1:0]   idx_q;
	logic [rbc_pkg::ENTRY_W-1:0] data_q;
	logic                        pres_q;

	logic                        status_q, opres_q;
	logic [rbc_pkg::ENTRY_W-1:0] odata_q;

	logic                        o_status_q, o_present_q, o_full_q, o_empty_q;
	logic [rbc_pkg::ENTRY_W-1:0] o_data_q;
	logic [rbc_pkg::CNT_W-1:0]   o_count_q;
	logic [rbc_pkg::POS_W-1:0]   o_wp_q, o_rp_q, o_cur_q;

	logic [rbc_pkg::CNT_W-1:0]   cap;
	logic                        empty;
	logic [rbc_pkg::CNT_W-1:0]   span;
	logic                        idx_bad;
	logic                        ignore;
	logic [rbc_pkg::POS_W-1:0]   rd_sel, raddr, waddr, shift_nxt, walk_lim, walk_nxt;
	logic [rbc_pkg::ENTRY_W-1:0] wdata;
	logic                        we;

	assign cap       = rbc_pkg::cap_eff(cap_q);
	assign empty     = !full_q && (wp_q == rp_q);
	assign idx_bad   = {1'b0, idx_q} >= cap;
	assign shift_nxt = rbc_pkg::pos_fwd(shift_q, cap);
	assign walk_lim  = (req_q == rbc_pkg::REQ_NEXT) ? wp_q : rp_q;
	assign walk_nxt  = (req_q == rbc_pkg::REQ_NEXT) ? rbc_pkg::pos_fwd(cur_q, cap)
		: rbc_pkg::pos_back(cur_q, cap);

	always_comb begin
		if (empty) begin
			span = '0;
		end else if (full_q) begin
			span = cap;
		end else if (wp_q >= rp_q) begin
			span = {1'b0, wp_q} - {1'b0, rp_q};
		end else begin
			span = cap - {1'b0, rp_q} + {1'b0, wp_q};
		end
	end

	always_comb begin
		case (req_q) inside
			rbc_pkg::REQ_ADD:                         ignore = full_q;
			rbc_pkg::REQ_RM_OLD, rbc_pkg::REQ_PEEK_CUR,
			rbc_pkg::REQ_NEXT:                        ignore = empty;
			rbc_pkg::REQ_RM_AT:                       ignore = idx_bad || empty;
			rbc_pkg::REQ_PEEK_AT, rbc_pkg::REQ_SET_AT: ignore = idx_bad;
			rbc_pkg::REQ_PREV, rbc_pkg::REQ_CLEAR:    ignore = 1'b0;
			default:                                  ignore = 1'b1;
		endcase
	end

	always_comb begin
		case (req_q) inside
			rbc_pkg::REQ_RM_OLD:   rd_sel = rp_q;
			rbc_pkg::REQ_PEEK_CUR: rd_sel = cur_q;
			default:               rd_sel = idx_q;
		endcase
	end

	assign stat.req        = req_q;
	assign stat.ignore     = ignore;
	assign stat.shift_last = (shift_nxt == wp_q);
	assign stat.walk_stop  = present_q[cur_q] || (cur_q == walk_lim);

	// Memory port selection.
	always_comb begin
		raddr = cmd.shift_rd ? shift_nxt : rd_sel;
		we    = 1'b0;
		waddr = wp_q;
		wdata = data_q;
		if (cmd.decode && !ignore && req_q == rbc_pkg::REQ_ADD) begin
			we = 1'b1;
		end else if (cmd.decode && !ignore && req_q == rbc_pkg::REQ_SET_AT) begin
			we    = pres_q;
			waddr = idx_q;
		end else if (cmd.shift_wr) begin
			we    = 1'b1;
			waddr = shift_q;
			wdata = rdata_q;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			req_q  <= req_type;
			idx_q  <= slot_index;
			data_q <= entry_data;
			pres_q <= entry_present;
		end
		if (cmd.decode) begin
			status_q <= ignore;
			opres_q  <= 1'b0;
			odata_q  <= '0;
			shift_q  <= idx_q;
		end else if (cmd.rd_capture) begin
			opres_q <= present_q[rd_sel];
			odata_q <= present_q[rd_sel] ? rdata_q : '0;
		end else if (cmd.shift_wr) begin
			shift_q <= shift_nxt;
		end
		if (cmd.out_load) begin
			o_status_q  <= status_q;
			o_present_q <= opres_q;
			o_data_q    <= odata_q;
			o_count_q   <= span;
			o_full_q    <= full_q;
			o_empty_q   <= empty;
			o_wp_q      <= wp_q;
			o_rp_q      <= rp_q;
			o_cur_q     <= cur_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q     <= rbc_pkg::CNT_W'(rbc_pkg::DEPTH);
			present_q <= '0;
			wp_q      <= '0;
			rp_q      <= '0;
			cur_q     <= '0;
			full_q    <= 1'b0;
		end else if (cfg_wr_en) begin
			cap_q     <= cfg_wr_data;
			present_q <= '0;
			wp_q      <= '0;
			rp_q      <= '0;
			cur_q     <= '0;
			full_q    <= 1'b0;
		end else if (cmd.decode && !ignore) begin
			case (req_q) inside
				rbc_pkg::REQ_ADD: begin
					present_q[wp_q] <= 1'b1;
					wp_q   <= rbc_pkg::pos_fwd(wp_q, cap);
					full_q <= (rbc_pkg::pos_fwd(wp_q, cap) == rp_q);
				end
				rbc_pkg::REQ_SET_AT: begin
					present_q[idx_q] <= pres_q;
				end
				rbc_pkg::REQ_CLEAR: begin
					present_q <= '0;
					wp_q      <= '0;
					rp_q      <= '0;
					cur_q     <= '0;
					full_q    <= 1'b0;
				end
				rbc_pkg::REQ_NEXT, rbc_pkg::REQ_PREV: begin
					cur_q <= walk_nxt;
				end
				default: begin
				end
			endcase
		end else if (cmd.rd_capture && req_q == rbc_pkg::REQ_RM_OLD) begin
			present_q[rp_q] <= 1'b0;
			full_q          <= 1'b0;
			if (rbc_pkg::pos_fwd(rp_q, cap) == wp_q) begin
				wp_q  <= '0;
				rp_q  <= '0;
				cur_q <= '0;
			end else begin
				rp_q <= rbc_pkg::pos_fwd(rp_q, cap);
			end
		end else if (cmd.shift_rd) begin
			if (shift_nxt == wp_q) begin
				wp_q   <= rbc_pkg::pos_back(wp_q, cap);
				present_q[rbc_pkg::pos_back(wp_q, cap)] <= 1'b0;
				full_q <= 1'b0;
			end else begin
				present_q[shift_q] <= present_q[shift_nxt];
			end
		end else if (cmd.walk_step && !stat.walk_stop) begin
			cur_q <= walk_nxt;
		end
	end

	assign status       = o_status_q;
	assign out_present  = o_present_q;
	assign out_data     = o_data_q;
	assign count        = o_count_q;
	assign full_res     = o_full_q;
	assign empty_res    = o_empty_q;
	assign write_index  = o_wp_q;
	assign read_index   = o_rp_q;
	assign cursor_index = o_cur_q;

endmodule

### rtl/ring_buffer_with_cursor_top.sv
// ----------------------------------------------------------------------------
// ring_buffer_with_cursor_top
// Ring FIFO of slots with a browsing cursor, one result word per request word.
// ----------------------------------------------------------------------------
// The request channel carries one operation per word: add, remove oldest,
// remove at a slot, peek at the cursor, move the cursor forward or back,
// peek at a slot, set a slot, or clear. Each request word yields exactly one
// result word on the result channel, with the status, any returned entry, the
// occupied count, the flags and the positions after the operation.
// Simple operations go from acceptance through the decode and finish states to
// the result register; the next request word is accepted once the controller
// is back in idle. Reads of the slot memory go through its registered read
// port. Remove at shifts later slots down with one read state and one write
// state per slot; cursor moves skip one empty slot per cycle. One request is
// worked on at a time. The capacity register is written through cfg_wr_en and
// cfg_wr_data; the user must write it only while the block is idle, which the
// block does not enforce. A write empties the buffer and clears all positions.
// After reset the capacity is 16 and the buffer is empty. A new request is
// accepted while a finished result waits in the output register; when the
// receiver stalls, the next result holds in the controller until taken.
// ----------------------------------------------------------------------------
module ring_buffer_with_cursor_top (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_wr_en,
	input  logic [rbc_pkg::CNT_W-1:0]  cfg_wr_data,
	rbc_req_if.sink                    request,
	rbc_rsp_if.source                  result
);

	rbc_pkg::ctl_cmd_t cmd;
	rbc_pkg::dp_stat_t stat;

	rbc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (request.valid),
		.in_ready  (request.ready),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	rbc_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.cmd           (cmd),
		.stat          (stat),
		.req_type      (request.req_type),
		.slot_index    (request.slot_index),
		.entry_data    (request.entry_data),
		.entry_present (request.entry_present),
		.status        (result.status),
		.out_present   (result.out_present),
		.out_data      (result.out_data),
		.count         (result.count),
		.full_res      (result.full_res),
		.empty_res     (result.empty_res),
		.write_index   (result.write_index),
		.read_index    (result.read_index),
		.cursor_index  (result.cursor_index)
	);

endmodule
